/* src/assert_macros.svh */
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* src/bdmp_pkg.sv */
// Shared constants and types for the box disparity mode position block.
package bdmp_pkg;

   localparam int MAX_PIXELS_DEF = 4096;
   localparam int HIST_BINS_DEF  = 1024;

   localparam int DIST_W = 24;
   localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

   // Shared divider: dividend enters left aligned, one quotient bit a cycle.
   localparam int DVD_W  = 56;
   localparam int DSR_W  = 25;
   localparam int ITER_W = 6;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BF       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DINF     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd4;

   typedef struct packed {
      logic              go;
      logic [ITER_W-1:0] iters;
   } div_req_type;

endpackage

/* src/bdmp_ram.sv */
// Simple dual port RAM, one write and one registered read per cycle.
module bdmp_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = bdmp_pkg::MAX_PIXELS_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/bdmp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module bdmp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  bdmp_pkg::div_req_type      req,
   input  logic [bdmp_pkg::DVD_W-1:0] dividend,
   input  logic [bdmp_pkg::DSR_W-1:0] divisor,
   output logic                       done,
   output logic [bdmp_pkg::DVD_W-1:0] quotient
);
   import bdmp_pkg::*;

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   logic [DSR_W:0]    rem_sh;
   logic [DSR_W+1:0]  diff;
   logic              fits;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
      fits   = !diff[DSR_W+1];
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.go) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = req.iters;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* src/box_disparity_mode_position.sv */
// Top level: per-box disparity to distance, histogram mode and box position.
//
//  channel  ports              handshake
//  -------  -----------------  --------------------------------------------
//  request  req_*              taken when start is high and busy is low
//  result   rsp_*              rsp_strobe high for one cycle, no backpressure
//  config   csr_*              written when csr_we is high, no wait
//
// A sample at or below the infinity disparity passes S_PX_CHK and S_PX_END,
// a valid sample also waits in S_PX_WAIT for the 32-step divide. The last
// sample of a box with valid samples then runs the bin window divides, the
// store pass, the histogram scan (read and clear) and, for a valid position,
// the x/y divides. Reset is synchronous; busy then stays high while the
// histogram is cleared bin by bin. The result side cannot stall.
module box_disparity_mode_position #(
   parameter int MAX_PIXELS = bdmp_pkg::MAX_PIXELS_DEF,
   parameter int HIST_BINS  = bdmp_pkg::HIST_BINS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           start,
   output logic                           busy,
   input  logic signed [12:0]             req_box_x,
   input  logic signed [12:0]             req_box_y,
   input  logic [11:0]                    req_box_w,
   input  logic [11:0]                    req_box_h,
   input  logic [15:0]                    req_disparity_q8,
   input  logic                           req_last_pixel,
   // result
   output logic                           rsp_strobe,
   output logic                           rsp_position_valid,
   output logic signed [31:0]             rsp_x_mm,
   output logic signed [31:0]             rsp_y_mm,
   output logic [23:0]                    rsp_z_cm,
   // configuration
   input  logic                           csr_we,
   input  logic [bdmp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdmp_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import bdmp_pkg::*;

`include "assert_macros.svh"

   localparam int AW     = $clog2(MAX_PIXELS);
   localparam int CW     = $clog2(MAX_PIXELS + 1);
   localparam int HW     = $clog2(HIST_BINS);
   localparam int RW     = $clog2(HIST_BINS + 1);
   localparam int SUM_W  = DIST_W + CW;
   localparam int NINE_W = SUM_W + 4;
   localparam int SW     = DIST_W + 1;   // start, end and mode
   localparam int ENT_W  = DIST_W + 1;   // stored distance plus valid mark

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_PX_CHK, S_PX_WAIT, S_PX_END,
      S_ST_GO, S_ST_WAIT, S_EN_GO, S_EN_WAIT,
      S_P2_RD, S_P2_CHK, S_P2_INC, S_SCAN, S_MODE, S_SCALE,
      S_X_MUL, S_X_GO, S_X_WAIT, S_Y_MUL, S_Y_GO, S_Y_WAIT, S_OUT
   } state_type;

   // configuration registers
   logic [15:0] baseline_ff;
   logic [23:0] bf_ff;
   logic [15:0] dinf_ff;
   logic [12:0] width_ff;
   logic [12:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= 16'd100;
         bf_ff       <= 24'd1;
         dinf_ff     <= 16'd0;
         width_ff    <= 13'd1280;
         height_ff   <= 13'd720;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASELINE: baseline_ff <= csr_wdata[15:0];
            CSR_BF:       bf_ff       <= csr_wdata[23:0];
            CSR_DINF:     dinf_ff     <= csr_wdata[15:0];
            CSR_WIDTH:    width_ff    <= csr_wdata[12:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // state
   state_type             state_ff, state_in;
   logic [CW-1:0]         pcount_ff, pcount_in;
   logic [CW-1:0]         vcount_ff, vcount_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [15:0]           disp_ff, disp_in;
   logic                  last_ff, last_in;
   logic signed [15:0]    rx_ff, rx_in, ry_ff, ry_in, rw_ff, rw_in, rh_ff, rh_in;
   logic [SW-1:0]         start_ff, start_in, end_ff, end_in;
   logic [RW-1:0]         rng_ff, rng_in, j_ff, j_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [HW-1:0]         bin_ff, bin_in;
   logic                  pipe_v_ff, pipe_v_in;
   logic [HW-1:0]         pipe_idx_ff, pipe_idx_in;
   logic [CW-1:0]         best_ff, best_in;
   logic [HW-1:0]         best_i_ff, best_i_in;
   logic [DIST_W-1:0]     z_ff, z_in;
   logic                  pv_ff, pv_in;
   logic [39:0]           scale_ff, scale_in;
   logic [DVD_W-1:0]      prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           xq_ff, xq_in, yq_ff, yq_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_pv_ff, rsp_pv_in;
   logic [31:0]           rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [23:0]           rsp_z_ff, rsp_z_in;

   // memories
   logic                  st_we;
   logic [ENT_W-1:0]      st_wdata, st_rdata;
   logic                  hi_we;
   logic [HW-1:0]         hi_waddr, hi_raddr;
   logic [CW-1:0]         hi_wdata, hi_rdata;

   // divider
   div_req_type           div_req;
   logic [DVD_W-1:0]      div_dvd, div_q;
   logic [DSR_W-1:0]      div_dsr;
   logic                  div_done;

   // datapath helpers
   logic                  accept;
   logic signed [15:0]    bx, by, bw1, bh1, img_w, img_h, lim_w, lim_h, top_w, top_h;
   logic signed [15:0]    cx, cy, cw, ch, ox, oy, oxy;
   logic [14:0]           mag;
   logic [NINE_W-1:0]     nine, eleven;
   logic [DSR_W-1:0]      den;
   logic [DIST_W-1:0]     dist_sat;
   logic [SW:0]           span;
   logic [SW-1:0]         v, vdiff, mode;
   logic                  in_bin;
   logic [CW-1:0]         i_nxt;

   function automatic logic [31:0] sat_quot(input logic [DVD_W-1:0] q, input logic neg);
      logic [31:0] r;
      if (!neg) begin
         r = (q > DVD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
      end else begin
         r = (q >= DVD_W'(32'h80000000)) ? 32'h80000000 : 32'(32'd0 - q[31:0]);
      end
      return r;
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // box clamp, all signed
   always_comb begin
      img_w = signed'({3'b000, width_ff});
      img_h = signed'({3'b000, height_ff});
      bx    = 16'(req_box_x);
      by    = 16'(req_box_y);
      bw1   = (req_box_w == 12'd0) ? 16'sd1 : signed'({4'b0000, req_box_w});
      bh1   = (req_box_h == 12'd0) ? 16'sd1 : signed'({4'b0000, req_box_h});
      cx    = (bx < 16'sd0) ? 16'sd0 : bx;
      cx    = (cx > img_w - 16'sd1) ? img_w - 16'sd1 : cx;
      cy    = (by < 16'sd0) ? 16'sd0 : by;
      cy    = (cy > img_h - 16'sd1) ? img_h - 16'sd1 : cy;
      lim_w = img_w - bx - 16'sd1;
      lim_h = img_h - by - 16'sd1;
      cw    = (bw1 < lim_w) ? bw1 : lim_w;
      ch    = (bh1 < lim_h) ? bh1 : lim_h;
      top_w = (img_w - cx < 16'sd0) ? 16'sd0 : img_w - cx;
      top_h = (img_h - cy < 16'sd0) ? 16'sd0 : img_h - cy;
      cw    = (cw < 16'sd0) ? 16'sd0 : cw;
      cw    = (cw > top_w) ? top_w : cw;
      ch    = (ch < 16'sd0) ? 16'sd0 : ch;
      ch    = (ch > top_h) ? top_h : ch;
      // center offsets in half pixels
      ox    = (rx_ff <<< 1) + rw_ff - img_w;
      oy    = img_h - (ry_ff <<< 1) - rh_ff;
      oxy   = (state_ff == S_X_MUL) ? ox : oy;
      mag   = oxy[15] ? 15'(16'sd0 - oxy) : oxy[14:0];
   end

   always_comb begin
      nine     = (NINE_W'(sum_ff) << 3) + NINE_W'(sum_ff);
      eleven   = (NINE_W'(sum_ff) << 3) + (NINE_W'(sum_ff) << 1) + NINE_W'(sum_ff);
      den      = (DSR_W'(vcount_ff) << 3) + (DSR_W'(vcount_ff) << 1);
      dist_sat = (div_q > DVD_W'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
      span     = {1'b0, div_q[SW-1:0]} - {1'b0, start_ff} + (SW+1)'(1);
      v        = {1'b0, st_rdata[DIST_W-1:0]};
      vdiff    = v - start_ff;
      in_bin   = st_rdata[DIST_W] && (v >= start_ff) && (v < end_ff)
                 && (vdiff < SW'(HIST_BINS));
      mode     = start_ff + SW'(best_i_ff);
      i_nxt    = i_ff + 1'b1;
   end

   // divider operand select
   always_comb begin
      div_req.go    = 1'b0;
      div_req.iters = ITER_W'(DVD_W);
      div_dvd       = prod_ff;
      div_dsr       = DSR_W'({bf_ff, 1'b0});
      unique case (state_ff)
         S_PX_CHK: begin
            div_req.go    = (pcount_ff < CW'(MAX_PIXELS)) && (disp_ff > dinf_ff);
            div_req.iters = ITER_W'(32);
            div_dvd       = DVD_W'({bf_ff, 8'd0}) << (DVD_W - 32);
            div_dsr       = DSR_W'(disp_ff - dinf_ff);
         end
         S_ST_GO: begin
            div_req.go    = 1'b1;
            div_req.iters = ITER_W'(NINE_W);
            div_dvd       = DVD_W'(nine) << (DVD_W - NINE_W);
            div_dsr       = den;
         end
         S_EN_GO: begin
            div_req.go    = 1'b1;
            div_req.iters = ITER_W'(NINE_W);
            div_dvd       = DVD_W'(eleven) << (DVD_W - NINE_W);
            div_dsr       = den;
         end
         S_X_GO, S_Y_GO: begin
            div_req.go = 1'b1;
         end
         default: ;
      endcase
   end

   // memory access
   always_comb begin
      st_we    = 1'b0;
      st_wdata = {1'b1, dist_sat};
      hi_we    = 1'b0;
      hi_waddr = bin_ff;
      hi_wdata = hi_rdata + 1'b1;
      hi_raddr = vdiff[HW-1:0];
      if (state_ff == S_PX_CHK && pcount_ff < CW'(MAX_PIXELS) && !(disp_ff > dinf_ff)) begin
         st_we    = 1'b1;
         st_wdata = '0;
      end
      if (state_ff == S_PX_WAIT && div_done) begin
         st_we = 1'b1;
      end
      if (state_ff == S_P2_INC) begin
         hi_we = 1'b1;
      end
      if (state_ff == S_SCAN) begin
         hi_raddr = j_ff[HW-1:0];
         hi_waddr = j_ff[HW-1:0];
         hi_wdata = '0;
         hi_we    = (j_ff < rng_ff);
      end
      // histogram cleared bin by bin after reset
      if (state_ff == S_CLR) begin
         hi_waddr = j_ff[HW-1:0];
         hi_wdata = '0;
         hi_we    = 1'b1;
      end
   end

   // control
   always_comb begin
      state_in      = state_ff;
      pcount_in     = pcount_ff;
      vcount_in     = vcount_ff;
      sum_in        = sum_ff;
      disp_in       = disp_ff;
      last_in       = last_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rw_in         = rw_ff;
      rh_in         = rh_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      rng_in        = rng_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      bin_in        = bin_ff;
      pipe_v_in     = pipe_v_ff;
      pipe_idx_in   = pipe_idx_ff;
      best_in       = best_ff;
      best_i_in     = best_i_ff;
      z_in          = z_ff;
      pv_in         = pv_ff;
      scale_in      = scale_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      xq_in         = xq_ff;
      yq_in         = yq_ff;
      rsp_strobe_in = 1'b0;
      rsp_pv_in     = rsp_pv_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;

      unique case (state_ff)
         S_CLR: begin
            j_in = j_ff + 1'b1;
            if (j_ff == RW'(HIST_BINS - 1)) begin
               j_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               disp_in = req_disparity_q8;
               last_in = req_last_pixel;
               if (pcount_ff == '0) begin
                  rx_in = cx;
                  ry_in = cy;
                  rw_in = cw;
                  rh_in = ch;
               end
               state_in = S_PX_CHK;
            end
         end
         S_PX_CHK: begin
            if (pcount_ff < CW'(MAX_PIXELS)) begin
               if (disp_ff > dinf_ff) begin
                  state_in = S_PX_WAIT;
               end else begin
                  pcount_in = pcount_ff + 1'b1;
                  state_in  = S_PX_END;
               end
            end else begin
               state_in = S_PX_END;
            end
         end
         S_PX_WAIT: begin
            if (div_done) begin
               sum_in    = sum_ff + SUM_W'(dist_sat);
               vcount_in = vcount_ff + 1'b1;
               pcount_in = pcount_ff + 1'b1;
               state_in  = S_PX_END;
            end
         end
         S_PX_END: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (vcount_ff == '0) begin
               pcount_in = '0;
               sum_in    = '0;
               state_in  = S_IDLE;
            end else begin
               state_in = S_ST_GO;
            end
         end
         S_ST_GO: state_in = S_ST_WAIT;
         S_ST_WAIT: begin
            if (div_done) begin
               start_in = div_q[SW-1:0];
               state_in = S_EN_GO;
            end
         end
         S_EN_GO: state_in = S_EN_WAIT;
         S_EN_WAIT: begin
            if (div_done) begin
               end_in    = div_q[SW-1:0];
               rng_in    = (span > (SW+1)'(HIST_BINS)) ? RW'(HIST_BINS) : span[RW-1:0];
               i_in      = '0;
               j_in      = '0;
               pipe_v_in = 1'b0;
               best_in   = '0;
               best_i_in = '0;
               state_in  = S_P2_RD;
            end
         end
         S_P2_RD: state_in = S_P2_CHK;
         S_P2_CHK: begin
            if (in_bin) begin
               bin_in   = vdiff[HW-1:0];
               state_in = S_P2_INC;
            end else begin
               i_in     = i_nxt;
               state_in = (i_nxt == pcount_ff) ? S_SCAN : S_P2_RD;
            end
         end
         S_P2_INC: begin
            i_in     = i_nxt;
            state_in = (i_nxt == pcount_ff) ? S_SCAN : S_P2_RD;
         end
         S_SCAN: begin
            // bins are read and cleared in the same pass
            if (j_ff < rng_ff) begin
               pipe_v_in   = 1'b1;
               pipe_idx_in = j_ff[HW-1:0];
               j_in        = j_ff + 1'b1;
            end else begin
               pipe_v_in = 1'b0;
            end
            if (pipe_v_ff && hi_rdata > best_ff) begin
               best_in   = hi_rdata;
               best_i_in = pipe_idx_ff;
            end
            if (j_ff == rng_ff && !pipe_v_ff) begin
               state_in = S_MODE;
            end
         end
         S_MODE: begin
            z_in     = (mode > SW'(DIST_MAX)) ? DIST_MAX : mode[DIST_W-1:0];
            pv_in    = (sum_ff != '0) && (mode != '0) && (bf_ff != '0);
            state_in = ((sum_ff != '0) && (mode != '0) && (bf_ff != '0)) ? S_SCALE : S_OUT;
         end
         S_SCALE: begin
            scale_in = 40'(baseline_ff) * 40'(z_ff);
            state_in = S_X_MUL;
         end
         S_X_MUL: begin
            prod_in  = DVD_W'(mag) * DVD_W'(scale_ff);
            neg_in   = oxy[15];
            state_in = S_X_GO;
         end
         S_X_GO: state_in = S_X_WAIT;
         S_X_WAIT: begin
            if (div_done) begin
               xq_in    = sat_quot(div_q, neg_ff);
               state_in = S_Y_MUL;
            end
         end
         S_Y_MUL: begin
            prod_in  = DVD_W'(mag) * DVD_W'(scale_ff);
            neg_in   = oxy[15];
            state_in = S_Y_GO;
         end
         S_Y_GO: state_in = S_Y_WAIT;
         S_Y_WAIT: begin
            if (div_done) begin
               yq_in    = sat_quot(div_q, neg_ff);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_pv_in     = pv_ff;
            rsp_x_in      = pv_ff ? xq_ff : 32'd0;
            rsp_y_in      = pv_ff ? yq_ff : 32'd0;
            rsp_z_in      = pv_ff ? z_ff : 24'd0;
            pcount_in     = '0;
            vcount_in     = '0;
            sum_in        = '0;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         pcount_ff     <= '0;
         vcount_ff     <= '0;
         sum_ff        <= '0;
         j_ff          <= '0;
         pipe_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rx_ff         <= '0;
         ry_ff         <= '0;
         rw_ff         <= '0;
         rh_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         pcount_ff     <= pcount_in;
         vcount_ff     <= vcount_in;
         sum_ff        <= sum_in;
         j_ff          <= j_in;
         pipe_v_ff     <= pipe_v_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rx_ff         <= rx_in;
         ry_ff         <= ry_in;
         rw_ff         <= rw_in;
         rh_ff         <= rh_in;
      end
      disp_ff     <= disp_in;
      last_ff     <= last_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      rng_ff      <= rng_in;
      i_ff        <= i_in;
      bin_ff      <= bin_in;
      pipe_idx_ff <= pipe_idx_in;
      best_ff     <= best_in;
      best_i_ff   <= best_i_in;
      z_ff        <= z_in;
      pv_ff       <= pv_in;
      scale_ff    <= scale_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      xq_ff       <= xq_in;
      yq_ff       <= yq_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_position_valid = rsp_pv_ff;
   assign rsp_x_mm           = signed'(rsp_x_ff);
   assign rsp_y_mm           = signed'(rsp_y_ff);
   assign rsp_z_cm           = rsp_z_ff;

   // distance store: valid mark above a 24-bit distance
   bdmp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (pcount_ff[AW-1:0]),
      .wdata (st_wdata),
      .raddr (i_ff[AW-1:0]),
      .rdata (st_rdata)
   );

   // 1-cm histogram, left all zero after every box
   bdmp_ram #(
      .WIDTH (CW),
      .DEPTH (HIST_BINS)
   ) u_hist (
      .clock (clock),
      .we    (hi_we),
      .waddr (hi_waddr),
      .wdata (hi_wdata),
      .raddr (hi_raddr),
      .rdata (hi_rdata)
   );

   bdmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   `ASSERT_CLK(a_strobe_idle, rsp_strobe |-> !busy, "result strobe outside idle")
   `ASSERT_CLK(a_strobe_pulse, rsp_strobe |=> !rsp_strobe, "result strobe longer than a cycle")
   `ASSERT_NEVER(a_invalid_zero, rsp_strobe && !rsp_position_valid &&
      (rsp_z_cm != 24'd0 || rsp_x_mm != 32'sd0 || rsp_y_mm != 32'sd0), "nonzero invalid result")
   `ASSERT_NEVER(a_counts, (vcount_ff > pcount_ff) || (pcount_ff > CW'(MAX_PIXELS)),
      "sample counters out of range")

endmodule

/* tb/tb_top.sv */
// Testbench for box_disparity_mode_position: directed and random boxes checked against a predictor.

typedef struct {
   bit              valid;
   int              x_mm;
   int              y_mm;
   bit [23:0]       z_cm;
} box_position_type;

class box_position_scoreboard;
   bit [15:0]        baseline;
   bit [23:0]        bf;
   bit [15:0]        dinf;
   bit [12:0]        img_w;
   bit [12:0]        img_h;
   bit [23:0]        dist_mem[4096];
   bit               ok_mem[4096];
   int unsigned      n_pix;
   int unsigned      n_valid;
   longint unsigned  dsum;
   int unsigned      hist[1024];
   longint           rx, ry, rw, rh;
   box_position_type expected_positions[$];
   int               mismatches;
   int               positions_seen;

   function void set_defaults();
      baseline = 100;
      bf       = 1;
      dinf     = 0;
      img_w    = 1280;
      img_h    = 720;
      rx = 0; ry = 0; rw = 0; rh = 0;
      clear_box();
   endfunction

   function void clear_box();
      n_pix   = 0;
      n_valid = 0;
      dsum    = 0;
      foreach (hist[i]) hist[i] = 0;
   endfunction

   function void write_reg(logic [bdmp_pkg::CSR_IDX_W-1:0] idx, logic [23:0] val);
      case (idx)
         bdmp_pkg::CSR_BASELINE: baseline = val[15:0];
         bdmp_pkg::CSR_BF:       bf       = val;
         bdmp_pkg::CSR_DINF:     dinf     = val[15:0];
         bdmp_pkg::CSR_WIDTH:    img_w    = val[12:0];
         bdmp_pkg::CSR_HEIGHT:   img_h    = val[12:0];
         default: ;
      endcase
   endfunction

   function int sat32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return int'(v);
   endfunction

   // predict the result (if any) caused by one accepted request
   function void note_request(logic signed [12:0] bx, logic signed [12:0] by,
                              logic [11:0] bw, logic [11:0] bh,
                              logic [15:0] d, bit last);
      longint           W, H, w1, h1, lim;
      longint unsigned  q, first, stop, span, best, best_i, mode, v;
      longint           scale, dv, ox, oy;
      box_position_type p;
      W = longint'(img_w);
      H = longint'(img_h);
      if (n_pix == 0) begin
         w1 = (bw == 0) ? 1 : longint'(bw);
         h1 = (bh == 0) ? 1 : longint'(bh);
         rx = longint'(bx);
         ry = longint'(by);
         if (rx < 0) rx = 0;
         if (rx > W - 1) rx = W - 1;
         if (ry < 0) ry = 0;
         if (ry > H - 1) ry = H - 1;
         rw = (w1 < W - longint'(bx) - 1) ? w1 : W - longint'(bx) - 1;
         rh = (h1 < H - longint'(by) - 1) ? h1 : H - longint'(by) - 1;
         lim = (W - rx < 0) ? 0 : W - rx;
         if (rw < 0) rw = 0;
         if (rw > lim) rw = lim;
         lim = (H - ry < 0) ? 0 : H - ry;
         if (rh < 0) rh = 0;
         if (rh > lim) rh = lim;
      end
      if (n_pix < 4096) begin
         dist_mem[n_pix] = 0;
         ok_mem[n_pix]   = 0;
         if (d > dinf) begin
            q = ({40'd0, bf} << 8) / longint'(d - dinf);
            dist_mem[n_pix] = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
            ok_mem[n_pix]   = 1;
            dsum += dist_mem[n_pix];
            n_valid++;
         end
         n_pix++;
      end
      if (!last) return;
      if (n_valid == 0) begin
         clear_box();
         return;
      end
      first = (9 * dsum) / (10 * longint'(n_valid));
      stop  = (11 * dsum) / (10 * longint'(n_valid));
      span  = stop - first + 1;
      if (span > 1024) span = 1024;
      for (int i = 0; i < n_pix; i++) begin
         v = dist_mem[i];
         if (ok_mem[i] && v >= first && v < stop && v - first < 1024) hist[v - first]++;
      end
      best   = hist[0];
      best_i = 0;
      for (int i = 0; i < span; i++)
         if (hist[i] > best) begin
            best   = hist[i];
            best_i = i;
         end
      mode = first + best_i;
      p.valid = (dsum != 0) && (mode > 0) && (bf != 0);
      p.x_mm = 0;
      p.y_mm = 0;
      p.z_cm = 0;
      if (p.valid) begin
         scale  = longint'(baseline) * longint'(mode);
         dv     = 2 * longint'(bf);
         ox     = 2 * rx + rw - W;
         oy     = H - 2 * ry - rh;
         p.x_mm = sat32((ox * scale) / dv);
         p.y_mm = sat32((oy * scale) / dv);
         p.z_cm = (mode > 64'hFFFFFF) ? 24'hFFFFFF : mode[23:0];
      end
      expected_positions = {expected_positions, p};
      clear_box();
   endfunction

   function void check_position(bit valid, int x_mm, int y_mm, bit [23:0] z_cm);
      box_position_type e;
      positions_seen++;
      if (expected_positions.size() == 0) begin
         $error("unexpected result: valid=%0d x=%0d y=%0d z=%0d", valid, x_mm, y_mm, z_cm);
         mismatches++;
         return;
      end
      e = expected_positions.pop_front();
      if (valid !== e.valid) begin
         $error("position_valid: expected %0d, actual %0d", e.valid, valid);
         mismatches++;
      end
      if (x_mm !== e.x_mm) begin
         $error("x_mm: expected %0d, actual %0d", e.x_mm, x_mm);
         mismatches++;
      end
      if (y_mm !== e.y_mm) begin
         $error("y_mm: expected %0d, actual %0d", e.y_mm, y_mm);
         mismatches++;
      end
      if (z_cm !== e.z_cm) begin
         $error("z_cm: expected %0d, actual %0d", e.z_cm, z_cm);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   import bdmp_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [12:0]   req_box_x;
   logic signed [12:0]   req_box_y;
   logic [11:0]          req_box_w;
   logic [11:0]          req_box_h;
   logic [15:0]          req_disparity_q8;
   logic                 req_last_pixel;
   logic                 rsp_strobe;
   logic                 rsp_position_valid;
   logic signed [31:0]   rsp_x_mm;
   logic signed [31:0]   rsp_y_mm;
   logic [23:0]          rsp_z_cm;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   box_position_scoreboard sb;
   bit idle_enable;      // sender gaps allowed in this stretch
   int requests_sent;
   int boxes_sent;

   box_disparity_mode_position dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // timeout guard: far beyond the slowest legal run
   initial begin
      #100000000;
      $display("Mismatches found");
      $finish;
   end

   // results cannot be held off: check every strobe as it passes
   always @(posedge clock)
      if (!reset && rsp_strobe)
         sb.check_position(rsp_position_valid, rsp_x_mm, rsp_y_mm, rsp_z_cm);

   // one register write; the enable drops again before the next write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int base, int bfv, int dinfv, int w, int h);
      csr_write(CSR_BASELINE, 24'(base));
      csr_write(CSR_BF, 24'(bfv));
      csr_write(CSR_DINF, 24'(dinfv));
      csr_write(CSR_WIDTH, 24'(w));
      csr_write(CSR_HEIGHT, 24'(h));
   endtask

   // Stop requesting, wait out all predicted positions, then idle a while so
   // that nothing is left in flight before the next register writes.
   task automatic drain();
      start <= 1'b0;
      while (sb.expected_positions.size() != 0) @(posedge clock);
      repeat (16000) @(posedge clock);
   endtask

   // One request; start stays high across back-to-back requests and only
   // drops when an idle burst follows.
   task automatic send_sample(logic signed [12:0] bx, logic signed [12:0] by,
                              logic [11:0] bw, logic [11:0] bh,
                              logic [15:0] d, bit last);
      start            <= 1'b1;
      req_box_x        <= bx;
      req_box_y        <= by;
      req_box_w        <= bw;
      req_box_h        <= bh;
      req_disparity_q8 <= d;
      req_last_pixel   <= last;
      do @(posedge clock); while (busy);
      sb.note_request(bx, by, bw, bh, d, last);
      requests_sent++;
      if (last) boxes_sent++;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // A box of npix samples clustered around one disparity offset above
   // infinity, with a share of noise samples anywhere in the 16-bit range.
   task automatic send_box(int npix, int off, int noise_pct);
      logic signed [12:0] bx, by;
      logic [11:0]        bw, bh;
      int                 d, jit;
      if ($urandom_range(0, 1)) begin
         bx = 13'($urandom_range(0, 8191));
         by = 13'($urandom_range(0, 8191));
      end else begin
         bx = 13'($urandom_range(0, sb.img_w - 1));
         by = 13'($urandom_range(0, sb.img_h - 1));
      end
      bw = 12'($urandom_range(0, 4095));
      bh = 12'($urandom_range(0, 4095));
      for (int i = 0; i < npix; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            d = $urandom_range(0, 65535);
         else begin
            jit = $urandom_range(0, off / 16 + 1);
            d   = sb.dinf + off + ($urandom_range(0, 1) ? jit : -jit);
         end
         if (d < 0) d = 0;
         if (d > 65535) d = 65535;
         send_sample(bx, by, bw, bh, d[15:0], i == npix - 1);
      end
   endtask

   // mostly small boxes, now and then 60 to 200 samples
   task automatic random_phase(int n_items, bit allow_idle);
      int target, npix, off;
      target = requests_sent + n_items;
      while (requests_sent < target) begin
         if (allow_idle && $urandom_range(0, 3) == 0)
            idle_enable = ($urandom_range(0, 1) == 1);
         npix = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                             : $urandom_range(1, 24);
         off  = ($urandom_range(0, 1)) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
         send_box(npix, off, $urandom_range(0, 1) ? 0 : 15);
      end
   endtask

   initial begin
      sb = new();
      sb.set_defaults();
      requests_sent = 0;
      boxes_sent    = 0;
      idle_enable   = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_box_x        <= '0;
      req_box_y        <= '0;
      req_box_w        <= '0;
      req_box_h        <= '0;
      req_disparity_q8 <= '0;
      req_last_pixel   <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset register values (bf 1: distances at most 256 cm)
      // no valid sample: no result, most negative corner, zero size
      send_sample(-13'sd4096, -13'sd4096, 12'd0, 12'd0, 16'd0, 1'b1);
      // zero sum: valid samples all round to 0 cm, far corner, max size
      send_sample(13'sd4095, 13'sd4095, 12'd4095, 12'd4095, 16'hFFFF, 1'b1);
      // spread-out distances: empty window, mode falls on bin 0
      send_sample(13'sd100, 13'sd50, 12'd40, 12'd30, 16'd1, 1'b0);
      send_sample(13'sd0, 13'sd0, 12'd0, 12'd0, 16'd2, 1'b0);
      send_sample(13'sd0, 13'sd0, 12'd0, 12'd0, 16'd3, 1'b1);
      // clear mode with an invalid sample mixed in; later box fields ignored
      send_sample(13'sd600, 13'sd300, 12'd80, 12'd60, 16'd16, 1'b0);
      send_sample(-13'sd1, 13'sd4095, 12'd4095, 12'd1, 16'd0, 1'b0);
      send_sample(13'sd0, 13'sd0, 12'd0, 12'd0, 16'd16, 1'b0);
      send_sample(13'sd0, 13'sd0, 12'd0, 12'd0, 16'd17, 1'b1);
      drain();

      // extremes: every sample at or below infinity, so no result at all
      configure(65535, 16777215, 65535, 4096, 4096);
      send_sample(13'sd10, 13'sd10, 12'd5, 12'd5, 16'hFFFF, 1'b0);
      send_sample(13'sd10, 13'sd10, 12'd5, 12'd5, 16'd0, 1'b1);
      drain();
      // distance saturation just above infinity
      configure(65535, 16777215, 65534, 1, 1);
      send_sample(13'sd0, 13'sd0, 12'd1, 12'd1, 16'hFFFF, 1'b1);
      send_sample(13'sd4095, -13'sd5, 12'd4095, 12'd0, 16'hFFFF, 1'b0);
      send_sample(13'sd0, 13'sd0, 12'd0, 12'd0, 16'hFFFF, 1'b1);
      drain();
      // small bf with a wide baseline drives x and y into saturation
      configure(65535, 3, 0, 4096, 4096);
      send_sample(13'sd4095, -13'sd4096, 12'd1, 12'd1, 16'd1, 1'b1);
      send_sample(13'sd0, 13'sd4095, 12'd1, 12'd1, 16'd1, 1'b1);
      drain();

      // --- random phases under varied settings
      configure($urandom_range(0, 65535), $urandom_range(1, 300000),
                $urandom_range(0, 4000), 1280, 720);
      idle_enable = 1;
      random_phase(200, 1'b1);
      drain();

      configure($urandom_range(0, 65535), $urandom_range(1, 8),
                $urandom_range(0, 16), 4096, 4096);
      random_phase(200, 1'b1);
      drain();

      configure(0, $urandom_range(1, 16777215), $urandom_range(0, 65535), 1, 1);
      random_phase(100, 1'b1);
      drain();

      configure($urandom_range(0, 65535), $urandom_range(1000, 100000),
                $urandom_range(0, 2000), $urandom_range(1, 4096), $urandom_range(1, 4096));
      random_phase(250, 1'b1);
      drain();

      // closing stretch runs back to back, no idling
      configure($urandom_range(0, 65535), $urandom_range(1, 50000),
                $urandom_range(0, 1000), $urandom_range(1, 4096), $urandom_range(1, 4096));
      idle_enable = 0;
      random_phase(250, 1'b0);
      drain();

      if (sb.expected_positions.size() != 0) begin
         $error("%0d predicted positions never arrived", sb.expected_positions.size());
         sb.mismatches++;
      end
      $display("Run covered %0d requests in %0d boxes, %0d positions checked.",
               requests_sent, boxes_sent, sb.positions_seen);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

/* sim.f */
+incdir+src
src/bdmp_pkg.sv
src/bdmp_ram.sv
src/bdmp_div.sv
src/box_disparity_mode_position.sv
tb/tb_top.sv
